FILE: src/clnms_pkg.sv
`timescale 1ns / 1ps
package clnms_pkg;
	localparam int unsigned OP_W = 2;
	localparam int unsigned COORD_W = 12;
	localparam int unsigned SCORE_W = 16;
	localparam int unsigned ENTRY_W = 2 * COORD_W + SCORE_W;

	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OP_W-1:0] OP_FETCH  = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic [COORD_W-1:0] corner_x;
		logic [COORD_W-1:0] corner_y;
		logic [SCORE_W-1:0] corner_score;
	} req_t;

	typedef struct packed {
		logic               found;
		logic [COORD_W-1:0] out_x;
		logic [COORD_W-1:0] out_y;
		logic [SCORE_W-1:0] out_score;
	} rsp_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [SCORE_W-1:0] score;
	} entry_t;

	// neighbour test: |nx - cx| <= 1 and ns >= cs
	function automatic logic is_neighbour(entry_t c, entry_t n);
		logic [COORD_W:0] nx1;
		logic [COORD_W:0] cx1;
		nx1 = {1'b0, n.x} + 1'b1;
		cx1 = {1'b0, c.x} + 1'b1;
		return (nx1 >= {1'b0, c.x}) && ({1'b0, n.x} <= cx1) && (n.score >= c.score);
	endfunction
endpackage

FILE: src/clnms_if.sv
`timescale 1ns / 1ps
interface clnms_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: src/clnms_ram.sv
`timescale 1ns / 1ps
module clnms_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: src/corner_list_nonmax_suppression_top.sv
`timescale 1ns / 1ps
// Channel | Dir | Payload
// req     | in  | operation, corner_x, corner_y, corner_score
// rsp     | out | found, out_x, out_y, out_score (fetch only)
//
// Append writes the store, then marks a new row in the row table; clear starts a
// sweep over all MAX_ROWS rows that empties the row table, and the same sweep runs
// after reset. req is not ready during the sweep. A fetch reads a candidate (S_CRD,
// S_NEXT), then per neighbour row reads the table (S_ROW, S_RWAIT) and checks the
// row's store entries (S_NRD/S_NCHK); a suppressed candidate stops at its suppressor.
// Stalls on rsp hold the result register, and req is not ready while it waits.
module corner_list_nonmax_suppression_top #(
	parameter int unsigned MAX_CORNERS = 1024,
	parameter int unsigned MAX_ROWS    = 4096
) (
	input  logic  clk,
	input  logic  arst_n,
	clnms_if.sink   req,
	clnms_if.source rsp
);
	import clnms_pkg::*;

	localparam int unsigned IW = $clog2(MAX_CORNERS);
	localparam int unsigned CW = IW + 1;
	localparam int unsigned RW = $clog2(MAX_ROWS);

	typedef enum logic [9:0] {
		S_SWEEP = 10'b0000000001,
		S_IDLE  = 10'b0000000010,
		S_CRD   = 10'b0000000100,
		S_CWAIT = 10'b0000001000,
		S_ROW   = 10'b0000010000,
		S_RWAIT = 10'b0000100000,
		S_NRD   = 10'b0001000000,
		S_NCHK  = 10'b0010000000,
		S_NEXT  = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;

	state_t state_q;
	logic [CW-1:0] count_q, cursor_q, idx_q, k_q;
	logic [RW-1:0] sweep_q;
	logic [1:0]    dr_q;
	entry_t        cand_q;
	logic [COORD_W:0] row_q;
	rsp_t          rsp_q;
	logic          rsp_valid_q;

	// corner store
	logic              st_we;
	logic [IW-1:0]     st_raddr;
	logic [ENTRY_W-1:0] st_rdata;
	entry_t            st_e;
	entry_t            new_e;

	// row table: {valid, first index}
	logic              rt_we;
	logic [RW-1:0]     rt_waddr, rt_raddr;
	logic [CW:0]       rt_wdata, rt_rdata;

	logic in_row_y, fits;

	assign new_e = '{x: req.data.corner_x, y: req.data.corner_y,
		score: req.data.corner_score};
	assign st_e = entry_t'(st_rdata);
	assign st_we = (state_q == S_IDLE) && req.valid && req.ready &&
		req.data.operation == OP_APPEND && count_q < CW'(MAX_CORNERS);
	assign in_row_y = (32'(req.data.corner_y) < 32'(MAX_ROWS));

	clnms_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_CORNERS)) u_store (
		.clk(clk), .we(st_we), .waddr(count_q[IW-1:0]), .wdata(new_e),
		.raddr(st_raddr), .rdata(st_rdata)
	);

	clnms_ram #(.WIDTH(CW + 1), .DEPTH(MAX_ROWS)) u_rows (
		.clk(clk), .we(rt_we), .waddr(rt_waddr), .wdata(rt_wdata),
		.raddr(rt_raddr), .rdata(rt_rdata)
	);

	// row table write: sweep clears, append marks on first corner of a row
	always_comb begin
		rt_we = 1'b0;
		rt_waddr = sweep_q;
		rt_wdata = '0;
		if (state_q == S_SWEEP) begin
			rt_we = 1'b1;
		end else if (state_q == S_CWAIT && rsp_q.found && !rt_rdata[CW]) begin
			// append, in S_CWAIT: rsp_q.found reused as "pending mark"
			rt_we = 1'b1;
			rt_waddr = RW'(cand_q.y);
			rt_wdata = {1'b1, idx_q};
		end
	end

	assign fits = (32'(row_q) < 32'(MAX_ROWS));
	assign rt_raddr = (state_q == S_IDLE) ? RW'(req.data.corner_y) : RW'(row_q);
	assign st_raddr = (state_q == S_IDLE || state_q == S_CRD || state_q == S_NEXT) ?
		cursor_q[IW-1:0] : k_q[IW-1:0];

	assign req.ready = (state_q == S_IDLE) && !rsp_valid_q;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			sweep_q <= '0;
			count_q <= '0;
			cursor_q <= '0;
			idx_q <= '0;
			k_q <= '0;
			dr_q <= '0;
			row_q <= '0;
			cand_q <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == RW'(MAX_ROWS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid && req.ready) begin
						case (req.data.operation)
							OP_CLEAR: begin
								count_q <= '0;
								cursor_q <= '0;
								sweep_q <= '0;
								state_q <= S_SWEEP;
							end
							OP_APPEND: begin
								if (st_we) begin
									cand_q <= new_e;
									idx_q <= count_q;
									rsp_q.found <= in_row_y;
									count_q <= count_q + 1'b1;
									state_q <= S_CWAIT;
								end
							end
							OP_FETCH: begin
								state_q <= S_CRD;
							end
							default: ;
						endcase
					end
				end
				S_CWAIT: begin
					// append: table write happens this cycle
					rsp_q.found <= 1'b0;
					state_q <= S_IDLE;
				end
				S_CRD: begin
					if (cursor_q >= count_q) begin
						rsp_q <= '0;
						rsp_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					// store data for cursor now valid
					cand_q <= st_e;
					idx_q <= cursor_q;
					cursor_q <= cursor_q + 1'b1;
					state_q <= S_ROW;
					if (st_e.y == '0) begin
						dr_q <= 2'd1;
						row_q <= {1'b0, st_e.y};
					end else begin
						dr_q <= 2'd0;
						row_q <= {1'b0, st_e.y} - 1'b1;
					end
				end
				S_ROW: begin
					// table read issued for row_q
					state_q <= S_RWAIT;
				end
				S_RWAIT: begin
					if (!fits || !rt_rdata[CW]) begin
						state_q <= S_OUT;
					end else begin
						k_q <= rt_rdata[CW-1:0];
						state_q <= S_NRD;
					end
				end
				S_NRD: begin
					if (k_q >= count_q) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_NCHK;
					end
				end
				S_NCHK: begin
					if ({1'b0, st_e.y} != row_q) begin
						state_q <= S_OUT;
					end else if (k_q != idx_q && is_neighbour(cand_q, st_e)) begin
						// suppressed: try next candidate
						state_q <= S_CRD;
					end else begin
						k_q <= k_q + 1'b1;
						state_q <= S_NRD;
					end
				end
				S_OUT: begin
					// row finished without suppression
					if (dr_q == 2'd2) begin
						rsp_q <= '{found: 1'b1, out_x: cand_q.x, out_y: cand_q.y,
							out_score: cand_q.score};
						rsp_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						dr_q <= dr_q + 1'b1;
						row_q <= row_q + 1'b1;
						state_q <= S_ROW;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: sim/corner_list_nonmax_suppression_top_tb.sv
`timescale 1ns / 1ps
module corner_list_nonmax_suppression_top_tb;
	import clnms_pkg::*;

	localparam int unsigned MAX_CORNERS = 1024;
	localparam int unsigned MAX_ROWS    = 4096;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int unsigned RANDOM_ITEMS = 560;
	localparam int unsigned STALL_LIMIT  = 300000;
	localparam int unsigned HOLD_CYCLES  = 600;
	localparam int unsigned CALM_FIRST   = 700;
	localparam int unsigned CALM_LAST    = 1000;

	logic clk;
	logic arst_n;

	clnms_if #(.payload_t(req_t)) req_ch ();
	clnms_if #(.payload_t(rsp_t)) rsp_ch ();

	corner_list_nonmax_suppression_top #(
		.MAX_CORNERS(MAX_CORNERS),
		.MAX_ROWS(MAX_ROWS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// stimulus backlog and expected survivors
	req_t req_backlog[$];
	rsp_t survivor_queue[$];

	// shadow of the corner list
	entry_t      shadow_store[MAX_CORNERS];
	int unsigned shadow_count;
	int unsigned shadow_cursor;
	int unsigned row_first[MAX_ROWS];
	bit          row_marked[MAX_ROWS];

	int unsigned fail_count;
	int unsigned req_accepted;
	int unsigned quiet_cycles;
	bit          req_fire;
	bit          hold_started;
	int unsigned hold_left;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void drop_list();
		shadow_count  = 0;
		shadow_cursor = 0;
		for (int r = 0; r < MAX_ROWS; r++) begin
			row_marked[r] = 1'b0;
			row_first[r]  = 0;
		end
	endfunction

	// does some other entry on row r hold a score >= entry self within one column
	function automatic bit row_beats(int unsigned r, int unsigned self);
		int unsigned cx;
		int unsigned cs;
		int unsigned nx;
		if (r >= MAX_ROWS || !row_marked[r])
			return 1'b0;
		cx = shadow_store[self].x;
		cs = shadow_store[self].score;
		for (int unsigned k = row_first[r];
				k < shadow_count && shadow_store[k].y == r; k++) begin
			nx = shadow_store[k].x;
			if (k != self && nx + 1 >= cx && nx <= cx + 1 && shadow_store[k].score >= cs)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bit is_local_max(int unsigned idx);
		int unsigned y;
		y = shadow_store[idx].y;
		if (y > 0 && row_beats(y - 1, idx))
			return 1'b0;
		return !row_beats(y, idx) && !row_beats(y + 1, idx);
	endfunction

	// apply one accepted transaction to the shadow list
	function automatic void track_request(req_t r);
		rsp_t        res;
		int unsigned idx;
		bit          hit;
		case (r.operation)
			OP_CLEAR: begin
				drop_list();
			end
			OP_APPEND: begin
				if (shadow_count < MAX_CORNERS) begin
					shadow_store[shadow_count] = '{x: r.corner_x, y: r.corner_y,
						score: r.corner_score};
					if (r.corner_y < MAX_ROWS && !row_marked[r.corner_y]) begin
						row_marked[r.corner_y] = 1'b1;
						row_first[r.corner_y]  = shadow_count;
					end
					shadow_count++;
				end
			end
			OP_FETCH: begin
				res = '0;
				hit = 1'b0;
				while (!hit && shadow_cursor < shadow_count) begin
					idx = shadow_cursor;
					shadow_cursor++;
					if (is_local_max(idx)) begin
						hit = 1'b1;
						res.found     = 1'b1;
						res.out_x     = shadow_store[idx].x;
						res.out_y     = shadow_store[idx].y;
						res.out_score = shadow_store[idx].score;
					end
				end
				survivor_queue = {survivor_queue, res};
			end
			default: ;
		endcase
	endfunction

	task automatic add_item(logic [OP_W-1:0] op, int unsigned x, int unsigned y,
			int unsigned s);
		req_t r;
		r.operation    = op;
		r.corner_x     = x[COORD_W-1:0];
		r.corner_y     = y[COORD_W-1:0];
		r.corner_score = s[SCORE_W-1:0];
		req_backlog = {req_backlog, r};
	endtask

	// clear, fetch or unused op with a random, ignored payload
	task automatic add_bare(logic [OP_W-1:0] op);
		add_item(op, $urandom_range(0, 4095), $urandom_range(0, 4095),
			$urandom_range(0, 65535));
	endtask

	// stimulus
	initial begin
		int unsigned n;
		int unsigned row_y;
		int unsigned col_x;
		int unsigned stored;
		int unsigned sel;

		arst_n        = 1'b0;
		req_ch.valid  = 1'b0;
		req_ch.data   = '0;
		rsp_ch.ready  = 1'b0;
		drop_list();

		// directed: extremes, ties, same position, ignored op, exhaustion
		add_item(OP_CLEAR, 0, 0, 0);
		add_item(OP_APPEND, 0, 0, 100);
		add_item(OP_APPEND, 1, 0, 100);
		add_item(OP_APPEND, 4095, 0, 65535);
		add_item(OP_APPEND, 4094, 1, 65534);
		add_item(OP_APPEND, 5, 1, 0);
		add_item(OP_APPEND, 5, 1, 0);
		add_item(OP_APPEND, 2, 2, 7);
		add_item(OP_UNUSED, 4095, 4095, 65535);
		add_item(OP_FETCH, 4095, 4095, 65535);
		add_item(OP_FETCH, 0, 0, 0);
		add_item(OP_FETCH, 0, 0, 0);
		add_item(OP_APPEND, 3, 3, 9);
		add_item(OP_APPEND, 100, 2, 50);
		add_item(OP_FETCH, 0, 0, 0);
		add_item(OP_FETCH, 0, 0, 0);
		add_item(OP_FETCH, 0, 0, 0);
		add_item(OP_APPEND, 4095, 4095, 1);
		add_item(OP_FETCH, 0, 0, 0);
		add_item(OP_FETCH, 0, 0, 0);
		add_item(OP_CLEAR, 0, 0, 0);
		add_item(OP_FETCH, 0, 0, 0);

		// random sessions of sorted corners with dense neighbourhoods
		stored = MAX_CORNERS;
		row_y  = 4095;
		while (req_backlog.size() < RANDOM_ITEMS) begin
			if (stored > 900 || row_y > 4040 || $urandom_range(0, 99) < 55) begin
				add_bare(OP_CLEAR);
				stored = 0;
				row_y  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
					: $urandom_range(0, 4040);
			end
			n     = $urandom_range(4, 40);
			col_x = $urandom_range(0, 4095);
			for (int i = 0; i < n; i++) begin
				sel = $urandom_range(0, 99);
				if (sel < 6) begin
					add_bare(OP_UNUSED);
				end else if (sel < 10) begin
					// out-of-order corner
					add_item(OP_APPEND, $urandom_range(0, 4095), $urandom_range(0, 4095),
						$urandom_range(0, 65535));
					stored++;
				end else begin
					if (col_x > 4090 || $urandom_range(0, 4) == 0) begin
						row_y += $urandom_range(1, 2);
						col_x  = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 4080);
					end else begin
						col_x += $urandom_range(1, 3);
					end
					add_item(OP_APPEND, col_x, row_y,
						($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
						: $urandom_range(0, 12) + (($urandom_range(0, 1)) ? 65523 : 0));
					stored++;
				end
				// some fetches interleaved with appends
				if ($urandom_range(0, 9) == 0)
					add_bare(OP_FETCH);
			end
			n = $urandom_range(n / 2, n + 3);
			for (int i = 0; i < n; i++)
				add_bare(OP_FETCH);
		end

		// fill the store past capacity, then drain a little
		add_bare(OP_CLEAR);
		row_y = 0;
		col_x = 0;
		for (int i = 0; i < MAX_CORNERS + 6; i++) begin
			if (i % 6 == 0) begin
				row_y++;
				col_x = $urandom_range(0, 8);
			end
			col_x += $urandom_range(1, 2);
			add_item(OP_APPEND, col_x, row_y, $urandom_range(0, 20));
		end
		for (int i = 0; i < 4; i++)
			add_bare(OP_FETCH);
		add_bare(OP_CLEAR);
		add_bare(OP_FETCH);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for every transaction and every survivor
		while (req_backlog.size() != 0 || req_ch.valid || survivor_queue.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("** corner_list_nonmax_suppression_top: PASSED **");
		else
			$display("** corner_list_nonmax_suppression_top: FAILED **");
		$finish;
	end

	// request driver
	always @(negedge clk) begin
		if (arst_n && (!req_ch.valid || req_fire)) begin
			if (req_backlog.size() != 0 && ((req_accepted >= CALM_FIRST
					&& req_accepted < CALM_LAST) || $urandom_range(0, 99) >= 30)) begin
				req_ch.valid <= 1'b1;
				req_ch.data  <= req_backlog.pop_front();
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// result receiver, with one long hold-off once fetches are flowing
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left    <= hold_left - 1;
				rsp_ch.ready <= 1'b0;
			end else if (!hold_started && req_accepted > 300 && survivor_queue.size() != 0) begin
				hold_started <= 1'b1;
				hold_left    <= HOLD_CYCLES;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= (req_accepted >= CALM_FIRST && req_accepted < CALM_LAST)
					|| $urandom_range(0, 99) >= 30;
			end
		end
	end

	// monitor: track requests, check results, watchdog
	always @(posedge clk) begin
		rsp_t want;
		bit   moved;
		moved = 1'b0;
		req_fire <= req_ch.valid && req_ch.ready;
		if (req_ch.valid && req_ch.ready) begin
			track_request(req_ch.data);
			req_accepted <= req_accepted + 1;
			moved = 1'b1;
		end
		if (rsp_ch.valid && rsp_ch.ready) begin
			moved = 1'b1;
			if (survivor_queue.size() == 0) begin
				$error("unexpected result transaction: %p", rsp_ch.data);
				fail_count++;
			end else begin
				want = survivor_queue.pop_front();
				if (rsp_ch.data.found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, rsp_ch.data.found);
					fail_count++;
				end
				if (rsp_ch.data.out_x !== want.out_x) begin
					$error("out_x: expected %0d, got %0d", want.out_x, rsp_ch.data.out_x);
					fail_count++;
				end
				if (rsp_ch.data.out_y !== want.out_y) begin
					$error("out_y: expected %0d, got %0d", want.out_y, rsp_ch.data.out_y);
					fail_count++;
				end
				if (rsp_ch.data.out_score !== want.out_score) begin
					$error("out_score: expected %0d, got %0d", want.out_score,
						rsp_ch.data.out_score);
					fail_count++;
				end
			end
		end
		quiet_cycles <= moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
			$display("** corner_list_nonmax_suppression_top: FAILED **");
			$finish;
		end
	end

	initial begin
		fail_count   = 0;
		req_accepted = 0;
		quiet_cycles = 0;
		req_fire     = 1'b0;
		hold_started = 1'b0;
		hold_left    = 0;
	end
endmodule
